[rtl/cttk_pkg.sv]
// Shared types, character constants and classification functions of the config text tokenizer.
package cttk_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_SECDOT  = 3'd1,
		MODE_SECTION = 3'd2,
		MODE_IDENT   = 3'd3,
		MODE_NUMBER  = 3'd4,
		MODE_STRING  = 3'd5,
		MODE_DEAD    = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		K_SECTION = 4'd0,
		K_IDENT   = 4'd1,
		K_TRUE    = 4'd2,
		K_FALSE   = 4'd3,
		K_INT     = 4'd4,
		K_FLOAT   = 4'd5,
		K_STRING  = 4'd6,
		K_COMMA   = 4'd7,
		K_OPEN    = 4'd8,
		K_CLOSE   = 4'd9,
		K_ERROR   = 4'd10
	} kind_t;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Keyword prefix tracker: 1..4 walk through "true", 5..9 through "false".
	localparam logic [3:0] KW_NONE   = 4'd0;
	localparam logic [3:0] KW_T      = 4'd1;
	localparam logic [3:0] KW_TRUE   = 4'd4;
	localparam logic [3:0] KW_F      = 4'd5;
	localparam logic [3:0] KW_FALSE  = 4'd9;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE;
	endfunction

	function automatic logic is_idch(input logic [7:0] c);
		return c == CH_UNDER || is_alpha(c) || is_digit(c);
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		if (c == CH_COMMA) begin
			k = K_COMMA;
		end else if (c == CH_LBRACE) begin
			k = K_OPEN;
		end else begin
			k = K_CLOSE;
		end
		return k;
	endfunction

	function automatic logic [3:0] kw_next(input logic [3:0] m, input logic [7:0] c);
		logic [7:0] want;
		logic       valid;
		valid = 1'b1;
		want  = "r";
		case (m)
			4'd1: want = "r";
			4'd2: want = "u";
			4'd3: want = "e";
			4'd5: want = "a";
			4'd6: want = "l";
			4'd7: want = "s";
			4'd8: want = "e";
			default: valid = 1'b0;
		endcase
		return (valid && c == want) ? m + 4'd1 : KW_NONE;
	endfunction

	function automatic kind_t pending_kind(input mode_t mode, input logic dot,
		input logic [3:0] kw);
		kind_t k;
		if (mode == MODE_SECTION) begin
			k = K_SECTION;
		end else if (mode == MODE_NUMBER) begin
			k = dot ? K_FLOAT : K_INT;
		end else if (kw == KW_TRUE) begin
			k = K_TRUE;
		end else if (kw == KW_FALSE) begin
			k = K_FALSE;
		end else begin
			k = K_IDENT;
		end
		return k;
	endfunction

endpackage

[rtl/cttk_lexer.sv]
// Input register and per-byte scanner state machine producing up to two tokens per byte.
module cttk_lexer import cttk_pkg::*; #(
	parameter int OW = 16,
	parameter int EW = 4 + 2 * OW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    ch,
	input  logic          end_of_text,
	input  logic          room,
	output logic [1:0]    push_count,
	output logic [EW-1:0] push_e0,
	output logic [EW-1:0] push_e1
);

	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic          eot_s1;
	logic          advance;

	mode_t         mode_q, mode_d;
	logic          dot_q, dot_d;
	logic [3:0]    kw_q, kw_d;
	logic [OW-1:0] pos_q, pos_d;
	logic [OW-1:0] tb_q, tb_d;

	logic [OW:0]   thru_full;
	logic [OW-1:0] thru;
	logic [OW-1:0] plen;
	logic [OW-1:0] one;
	logic [1:0]    n;
	kind_t         k0, k1;
	logic [OW-1:0] s0, s1, l0, l1;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;
	assign one      = {{(OW-1){1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1  <= ch;
			eot_s1 <= end_of_text;
		end
	end

	// Length through the current byte, saturated at the top offset.
	assign thru_full = {1'b0, pos_q} + {{OW{1'b0}}, 1'b1} - {1'b0, tb_q};
	assign plen      = pos_q - tb_q;

	always_comb begin
		mode_d = mode_q;
		dot_d  = dot_q;
		kw_d   = kw_q;
		tb_d   = tb_q;
		pos_d  = (pos_q == {OW{1'b1}}) ? pos_q : pos_q + one;
		if (mode_q == MODE_IDLE) begin
			thru = one;
		end else begin
			thru = thru_full[OW] ? {OW{1'b1}} : thru_full[OW-1:0];
		end
		n  = 2'd0;
		k0 = K_ERROR;
		s0 = tb_q;
		l0 = thru;
		k1 = punct_kind(ch_s1);
		s1 = pos_q;
		l1 = one;

		case (mode_q)
			MODE_IDLE: begin
				tb_d = pos_q;
				if (ch_s1 == CH_DOT) begin
					mode_d = MODE_SECDOT;
				end else if (is_alpha(ch_s1)) begin
					mode_d = MODE_IDENT;
					kw_d   = (ch_s1 == "t") ? KW_T : (ch_s1 == "f") ? KW_F : KW_NONE;
				end else if (ch_s1 == CH_PLUS || ch_s1 == CH_MINUS || is_digit(ch_s1)) begin
					mode_d = MODE_NUMBER;
					dot_d  = 1'b0;
				end else if (ch_s1 == CH_QUOTE) begin
					mode_d = MODE_STRING;
				end else if (is_punct(ch_s1)) begin
					n  = 2'd1;
					k0 = punct_kind(ch_s1);
					s0 = pos_q;
					l0 = one;
				end else if (!is_space(ch_s1)) begin
					n      = 2'd1;
					k0     = K_ERROR;
					s0     = pos_q;
					l0     = one;
					mode_d = MODE_DEAD;
				end
			end
			MODE_SECDOT: begin
				if (is_alpha(ch_s1)) begin
					mode_d = MODE_SECTION;
				end else begin
					n      = 2'd1;
					mode_d = MODE_DEAD;
				end
			end
			MODE_SECTION, MODE_IDENT, MODE_NUMBER: begin
				if (is_space(ch_s1) || is_punct(ch_s1)) begin
					// The pending token goes out first, then the punctuation itself.
					n      = is_punct(ch_s1) ? 2'd2 : 2'd1;
					k0     = pending_kind(mode_q, dot_q, kw_q);
					l0     = plen;
					mode_d = MODE_IDLE;
				end else if (mode_q == MODE_NUMBER) begin
					if (ch_s1 == CH_DOT && !dot_q) begin
						dot_d = 1'b1;
					end else if (!is_digit(ch_s1)) begin
						n      = 2'd1;
						mode_d = MODE_DEAD;
					end
				end else if (is_idch(ch_s1)) begin
					kw_d = kw_next(kw_q, ch_s1);
				end else begin
					n      = 2'd1;
					mode_d = MODE_DEAD;
				end
			end
			MODE_STRING: begin
				if (ch_s1 == CH_NL) begin
					n      = 2'd1;
					mode_d = MODE_DEAD;
				end else if (ch_s1 == CH_QUOTE) begin
					n      = 2'd1;
					k0     = K_STRING;
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_DEAD;
			end
		endcase

		// A byte that emits always leaves the name, number and string modes, so the
		// end-of-stream flush only ever lands in the first slot.
		if (eot_s1) begin
			if (mode_d == MODE_SECDOT) begin
				n  = 2'd1;
				k0 = K_ERROR;
				s0 = tb_d;
				l0 = thru;
			end else if (mode_d == MODE_STRING) begin
				n  = 2'd1;
				k0 = K_STRING;
				s0 = tb_d;
				l0 = thru;
			end else if (mode_d == MODE_SECTION || mode_d == MODE_IDENT ||
				mode_d == MODE_NUMBER) begin
				n  = 2'd1;
				k0 = pending_kind(mode_d, dot_d, kw_d);
				s0 = tb_d;
				l0 = thru;
			end
			mode_d = MODE_IDLE;
			dot_d  = 1'b0;
			kw_d   = KW_NONE;
			pos_d  = '0;
			tb_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			dot_q  <= 1'b0;
			kw_q   <= KW_NONE;
			pos_q  <= '0;
			tb_q   <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			dot_q  <= dot_d;
			kw_q   <= kw_d;
			pos_q  <= pos_d;
			tb_q   <= tb_d;
		end
	end

	assign push_count = advance ? n : 2'd0;
	assign push_e0    = {k0, s0, l0, (n == 2'd1)};
	assign push_e1    = {k1, s1, l1, 1'b1};

endmodule

[rtl/cttk_fifo.sv]
// Four-entry result queue that takes up to two tokens per cycle and delivers one.
module cttk_fifo #(
	parameter int EW = 37
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_count,
	input  logic [EW-1:0] push_e0,
	input  logic [EW-1:0] push_e1,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [EW-1:0] out_data
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [EW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   count_q;
	logic          pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	// Room for a full pair regardless of whether the head leaves this cycle.
	assign room      = count_q <= (PW + 1)'(DEPTH - 2);
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push_count);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + (PW + 1)'(push_count) - (PW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_q] <= push_e0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= push_e1;
		end
	end

endmodule

[rtl/config_text_tokenizer.sv]
// Top level of the config text tokenizer: byte scanner followed by the result queue.
// A token's result passes the input register, then the four-entry queue, to the output.
// Throughput: one byte per cycle while the queue has room; a byte that closes a token with a
// comma or brace yields two results; the queue drains one a cycle while out_ready is high.
// Reset: arst_n clears the scanner state, the input stage and the queue at once; each
// end_of_text byte also returns the scanner to its reset state for the next stream.
module config_text_tokenizer import cttk_pkg::*; #(
	parameter int OFFSET_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              ch,
	input  logic                    end_of_text,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [3:0]              kind,
	output logic [OFFSET_WIDTH-1:0] start_offset,
	output logic [OFFSET_WIDTH-1:0] token_length,
	output logic                    last_of_run
);

	localparam int EW = 4 + 2 * OFFSET_WIDTH + 1;

	logic          room;
	logic [1:0]    push_count;
	logic [EW-1:0] push_e0, push_e1, out_data;

	cttk_lexer #(.OW(OFFSET_WIDTH), .EW(EW)) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.end_of_text(end_of_text),
		.room       (room),
		.push_count (push_count),
		.push_e0    (push_e0),
		.push_e1    (push_e1)
	);

	cttk_fifo #(.EW(EW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_count(push_count),
		.push_e0   (push_e0),
		.push_e1   (push_e1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign kind         = out_data[EW-1 -: 4];
	assign start_offset = out_data[2*OFFSET_WIDTH : OFFSET_WIDTH+1];
	assign token_length = out_data[OFFSET_WIDTH : 1];
	assign last_of_run  = out_data[0];

endmodule
